### src/bbps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_pkg
// Types and constants shared by the buzzer pattern sequencer files.
// ----------------------------------------------------------------------------
package bbps_pkg;

   localparam int unsigned FIELD_WIDTH = 16;

   typedef enum logic [2:0] {
      OP_TICK          = 3'd0,
      OP_BUTTON        = 3'd1,
      OP_SETTING       = 3'd2,
      OP_WARNING       = 3'd3,
      OP_CLEAR_WARNING = 3'd4,
      OP_FORCED_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_BUTTON  = 2'd1,
      KIND_SETTING = 2'd2,
      KIND_WARNING = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CSR_BUTTON_COUNT     = 3'd0,
      CSR_BUTTON_PERIOD    = 3'd1,
      CSR_BUTTON_ON_TIME   = 3'd2,
      CSR_BUTTON_OFF_TIME  = 3'd3,
      CSR_SETTING_COUNT    = 3'd4,
      CSR_SETTING_PERIOD   = 3'd5,
      CSR_SETTING_ON_TIME  = 3'd6,
      CSR_SETTING_OFF_TIME = 3'd7
   } csr_index_type;

   localparam logic [FIELD_WIDTH-1:0] BUTTON_COUNT_RESET     = 16'd1;
   localparam logic [FIELD_WIDTH-1:0] BUTTON_PERIOD_RESET    = 16'd300;
   localparam logic [FIELD_WIDTH-1:0] BUTTON_ON_TIME_RESET   = 16'd300;
   localparam logic [FIELD_WIDTH-1:0] BUTTON_OFF_TIME_RESET  = 16'd1000;
   localparam logic [FIELD_WIDTH-1:0] SETTING_COUNT_RESET    = 16'd3;
   localparam logic [FIELD_WIDTH-1:0] SETTING_PERIOD_RESET   = 16'd1000;
   localparam logic [FIELD_WIDTH-1:0] SETTING_ON_TIME_RESET  = 16'd6000;
   localparam logic [FIELD_WIDTH-1:0] SETTING_OFF_TIME_RESET = 16'd0;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] count;
      logic [FIELD_WIDTH-1:0] period;
      logic [FIELD_WIDTH-1:0] on_time;
      logic [FIELD_WIDTH-1:0] off_time;
   } pattern_type;

   typedef struct packed {
      logic [2:0]             operation;
      logic [FIELD_WIDTH-1:0] warn_count;
      logic [FIELD_WIDTH-1:0] warn_period;
      logic [FIELD_WIDTH-1:0] warn_on_time;
      logic [FIELD_WIDTH-1:0] warn_off_time;
   } req_payload_type;

   typedef struct packed {
      logic       buzzer;
      logic [1:0] sound_kind;
      logic       playing;
   } rsp_payload_type;

endpackage
`default_nettype wire

### src/bbps_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bbps_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/bbps_csr_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_csr_regs
// Button and setting pattern registers with a plain write port.
// ----------------------------------------------------------------------------
module bbps_csr_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [bbps_pkg::FIELD_WIDTH-1:0]    csr_write_data,
   output bbps_pkg::pattern_type                    button_pattern,
   output bbps_pkg::pattern_type                    setting_pattern
);

   bbps_pkg::pattern_type button_ff;
   bbps_pkg::pattern_type setting_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         button_ff.count     <= bbps_pkg::BUTTON_COUNT_RESET;
         button_ff.period    <= bbps_pkg::BUTTON_PERIOD_RESET;
         button_ff.on_time   <= bbps_pkg::BUTTON_ON_TIME_RESET;
         button_ff.off_time  <= bbps_pkg::BUTTON_OFF_TIME_RESET;
         setting_ff.count    <= bbps_pkg::SETTING_COUNT_RESET;
         setting_ff.period   <= bbps_pkg::SETTING_PERIOD_RESET;
         setting_ff.on_time  <= bbps_pkg::SETTING_ON_TIME_RESET;
         setting_ff.off_time <= bbps_pkg::SETTING_OFF_TIME_RESET;
      end else if (csr_write_enable) begin
         case (bbps_pkg::csr_index_type'(csr_index))
            bbps_pkg::CSR_BUTTON_COUNT:     button_ff.count     <= csr_write_data;
            bbps_pkg::CSR_BUTTON_PERIOD:    button_ff.period    <= csr_write_data;
            bbps_pkg::CSR_BUTTON_ON_TIME:   button_ff.on_time   <= csr_write_data;
            bbps_pkg::CSR_BUTTON_OFF_TIME:  button_ff.off_time  <= csr_write_data;
            bbps_pkg::CSR_SETTING_COUNT:    setting_ff.count    <= csr_write_data;
            bbps_pkg::CSR_SETTING_PERIOD:   setting_ff.period   <= csr_write_data;
            bbps_pkg::CSR_SETTING_ON_TIME:  setting_ff.on_time  <= csr_write_data;
            bbps_pkg::CSR_SETTING_OFF_TIME: setting_ff.off_time <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign button_pattern  = button_ff;
   assign setting_pattern = setting_ff;

endmodule
`default_nettype wire

### src/bbps_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_engine
// Pattern state and single-pass update for one transaction; presents the
// state after the update as the result.
// ----------------------------------------------------------------------------
module bbps_engine #(
   parameter int unsigned TICK_MS     = 2,
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  bbps_pkg::req_payload_type     req_item,
   input  bbps_pkg::pattern_type         button_pattern,
   input  bbps_pkg::pattern_type         setting_pattern,
   output bbps_pkg::rsp_payload_type     result
);

   localparam int unsigned FW = bbps_pkg::FIELD_WIDTH;
   localparam int unsigned TW = TIMER_WIDTH;
   localparam int unsigned CW = (TIMER_WIDTH > FW) ? TIMER_WIDTH : FW;
   localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};
   localparam logic [TW:0]   TICK_STEP = (TW+1)'(TICK_MS);

   bbps_pkg::kind_type active_kind_ff, active_kind_in;
   bbps_pkg::kind_type last_kind_ff, last_kind_in;
   logic               play_ff, play_in;
   logic               buzzer_ff, buzzer_in;
   logic [FW-1:0]      done_ff, done_in;
   logic [FW-1:0]      target_ff, target_in;
   logic [FW-1:0]      period_ff, period_in;
   logic [FW-1:0]      on_window_ff, on_window_in;
   logic [FW-1:0]      off_window_ff, off_window_in;
   logic [TW-1:0]      dur_timer_ff, dur_timer_in;
   logic [TW-1:0]      per_timer_ff, per_timer_in;

   logic [TW:0]           dur_sum;
   logic [TW:0]           per_sum;
   logic [TW-1:0]         dur_step;
   logic [TW-1:0]         per_step;
   logic                  do_start;
   logic                  do_clear;
   bbps_pkg::kind_type    start_kind;
   bbps_pkg::pattern_type start_pattern;
   bbps_pkg::pattern_type warn_pattern;

   assign dur_sum  = {1'b0, dur_timer_ff} + TICK_STEP;
   assign per_sum  = {1'b0, per_timer_ff} + TICK_STEP;
   assign dur_step = play_ff ? (dur_sum[TW] ? TIMER_MAX : dur_sum[TW-1:0]) : '0;
   assign per_step = play_ff ? (per_sum[TW] ? TIMER_MAX : per_sum[TW-1:0]) : '0;

   assign warn_pattern.count    = req_item.warn_count;
   assign warn_pattern.period   = req_item.warn_period;
   assign warn_pattern.on_time  = req_item.warn_on_time;
   assign warn_pattern.off_time = req_item.warn_off_time;

   always_comb begin
      active_kind_in = active_kind_ff;
      last_kind_in   = last_kind_ff;
      play_in        = play_ff;
      buzzer_in      = buzzer_ff;
      done_in        = done_ff;
      target_in      = target_ff;
      period_in      = period_ff;
      on_window_in   = on_window_ff;
      off_window_in  = off_window_ff;
      dur_timer_in   = dur_timer_ff;
      per_timer_in   = per_timer_ff;
      do_start       = 1'b0;
      do_clear       = 1'b0;
      start_kind     = bbps_pkg::KIND_BUTTON;
      start_pattern  = button_pattern;

      case (bbps_pkg::op_type'(req_item.operation))
         bbps_pkg::OP_TICK: begin
            dur_timer_in = dur_step;
            per_timer_in = per_step;
            if (active_kind_ff == bbps_pkg::KIND_NONE) begin
               dur_timer_in = '0;
               per_timer_in = '0;
               buzzer_in    = 1'b0;
            end else if (!play_ff) begin
               buzzer_in = 1'b0;
            end else if (CW'(dur_step) <= CW'(on_window_ff)) begin
               if (done_ff < target_ff) begin
                  if (CW'(per_step) < CW'(period_ff >> 1)) begin
                     buzzer_in = 1'b1;
                  end else if (CW'(per_step) < CW'(period_ff)) begin
                     buzzer_in = 1'b0;
                  end else begin
                     per_timer_in = '0;
                     buzzer_in    = 1'b0;
                     done_in      = done_ff + FW'(1);
                  end
               end else begin
                  last_kind_in   = active_kind_ff;
                  buzzer_in      = 1'b0;
                  play_in        = 1'b0;
                  active_kind_in = bbps_pkg::KIND_NONE;
               end
            end else if (CW'(dur_step) <= CW'(off_window_ff)) begin
               buzzer_in = 1'b0;
            end else begin
               dur_timer_in = '0;
            end
         end
         bbps_pkg::OP_BUTTON: begin
            do_start = 1'b1;
         end
         bbps_pkg::OP_SETTING: begin
            start_kind    = bbps_pkg::KIND_SETTING;
            start_pattern = setting_pattern;
            do_start      = (active_kind_ff == bbps_pkg::KIND_NONE) &&
                            (last_kind_ff != bbps_pkg::KIND_SETTING);
         end
         bbps_pkg::OP_WARNING: begin
            start_kind    = bbps_pkg::KIND_WARNING;
            start_pattern = warn_pattern;
            do_start      = (active_kind_ff == bbps_pkg::KIND_NONE) &&
                            (last_kind_ff != bbps_pkg::KIND_WARNING);
         end
         bbps_pkg::OP_CLEAR_WARNING: begin
            do_clear = (active_kind_ff == bbps_pkg::KIND_WARNING);
         end
         bbps_pkg::OP_FORCED_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
         end
      endcase

      if (do_start) begin
         active_kind_in = start_kind;
         play_in        = 1'b1;
         done_in        = '0;
         target_in      = start_pattern.count;
         period_in      = start_pattern.period;
         on_window_in   = start_pattern.on_time;
         off_window_in  = start_pattern.off_time;
         dur_timer_in   = '0;
         per_timer_in   = '0;
      end
      if (do_clear) begin
         active_kind_in = bbps_pkg::KIND_NONE;
         play_in        = 1'b0;
         last_kind_in   = bbps_pkg::KIND_NONE;
         done_in        = '0;
         target_in      = '0;
         period_in      = '0;
         on_window_in   = '0;
         off_window_in  = '0;
         dur_timer_in   = '0;
         per_timer_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_kind_ff <= bbps_pkg::KIND_NONE;
         last_kind_ff   <= bbps_pkg::KIND_NONE;
         play_ff        <= 1'b0;
         buzzer_ff      <= 1'b0;
         done_ff        <= '0;
         target_ff      <= '0;
         period_ff      <= '0;
         on_window_ff   <= '0;
         off_window_ff  <= '0;
         dur_timer_ff   <= '0;
         per_timer_ff   <= '0;
      end else if (fire) begin
         active_kind_ff <= active_kind_in;
         last_kind_ff   <= last_kind_in;
         play_ff        <= play_in;
         buzzer_ff      <= buzzer_in;
         done_ff        <= done_in;
         target_ff      <= target_in;
         period_ff      <= period_in;
         on_window_ff   <= on_window_in;
         off_window_ff  <= off_window_in;
         dur_timer_ff   <= dur_timer_in;
         per_timer_ff   <= per_timer_in;
      end
   end

   assign result.buzzer     = buzzer_in;
   assign result.sound_kind = active_kind_in;
   assign result.playing    = play_in;

`ifndef SYNTHESIS
   a_play_matches_kind: assert property (@(posedge clock) disable iff (reset)
      play_ff == (active_kind_ff != bbps_pkg::KIND_NONE))
      else $error("play flag and active kind disagree");

   a_idle_timers_zero: assert property (@(posedge clock) disable iff (reset)
      fire && (active_kind_ff == bbps_pkg::KIND_NONE) &&
      (req_item.operation == bbps_pkg::OP_TICK) |=>
      (dur_timer_ff == '0) && (per_timer_ff == '0) && !buzzer_ff)
      else $error("tick with no pattern left timers or buzzer active");

   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      fire && play_ff && (done_ff == target_ff) &&
      (req_item.operation == bbps_pkg::OP_TICK) |=> $stable(done_ff))
      else $error("period count advanced past its target");
`endif

endmodule
`default_nettype wire

### src/buzzer_beep_pattern_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_beep_pattern_sequencer_core
// Buzzer pattern sequencer: ticks and sound requests in, buzzer state out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake     payload
//  req      in         valid/ready   operation, warn_count/period/on/off time
//  rsp      out        valid/ready   buzzer, sound_kind, playing
//  csr      in         write enable  csr_index, csr_write_data
//
//  One transaction per cycle while rsp is not stalled; an accepted item
//  enters the input register, then the result register (single-pass update).
//  A stalled result holds the input register, which in turn drops req ready.
//  Reset is synchronous and returns the valid flags, engine state and CSRs to their defaults.
// ----------------------------------------------------------------------------
module buzzer_beep_pattern_sequencer_core #(
   parameter int unsigned TICK_MS     = 2,
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bbps_stream_if.sink                           req_channel,
   bbps_stream_if.source                         rsp_channel,
   input  wire logic                             csr_write_enable,
   input  wire logic [2:0]                       csr_index,
   input  wire logic [bbps_pkg::FIELD_WIDTH-1:0] csr_write_data
);

   bbps_pkg::pattern_type     button_pattern;
   bbps_pkg::pattern_type     setting_pattern;
   bbps_pkg::req_payload_type in_item_ff;
   bbps_pkg::rsp_payload_type out_item_ff;
   bbps_pkg::rsp_payload_type engine_result;
   logic                      in_valid_ff, in_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      advance;
   logic                      req_fire;

   bbps_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .button_pattern   (button_pattern),
      .setting_pattern  (setting_pattern)
   );

   bbps_engine #(
      .TICK_MS     (TICK_MS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .fire            (advance),
      .req_item        (in_item_ff),
      .button_pattern  (button_pattern),
      .setting_pattern (setting_pattern),
      .result          (engine_result)
   );

   assign advance           = in_valid_ff && (!out_valid_ff || rsp_channel.ready);
   assign req_channel.ready = !in_valid_ff || advance;
   assign req_fire          = req_channel.valid && req_channel.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_channel.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_channel.payload;
      end
      if (advance) begin
         out_item_ff <= engine_result;
      end
   end

   assign rsp_channel.valid   = out_valid_ff;
   assign rsp_channel.payload = out_item_ff;

`ifndef SYNTHESIS
   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      req_channel.valid && req_channel.ready |=> in_valid_ff)
      else $error("accepted transaction did not reach the input register");

   a_free_output_advances: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("input register did not move into an empty result register");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_channel.ready |=>
      in_valid_ff && $stable(in_item_ff))
      else $error("input register changed while the result was stalled");
`endif

endmodule
`default_nettype wire
